>>> design/hamming_secded_block_codec_macros.svh
// Assertion macros used by the codec top module.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef HAMMING_SECDED_BLOCK_CODEC_MACROS_SVH
`define HAMMING_SECDED_BLOCK_CODEC_MACROS_SVH

// Overlapping implication, checked outside reset.
`define HSC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("codec assertion failed");

// Non-overlapping implication, checked outside reset.
`define HSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("codec assertion failed");

`endif

>>> design/hsc_pkg.sv
package hsc_pkg;

  localparam int CODE_W = 64;
  localparam int SYN_W  = 6;
  localparam int CNT_W  = 7;

  // Input command codes.
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAN  = 2'd0,
    ST_SINGLE = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  // Word after the placement stage.
  typedef struct packed {
    logic              cmd;
    logic [CODE_W-1:0] cw;
  } place_t;

  // Word after the syndrome stage.
  typedef struct packed {
    logic              cmd;
    logic [CODE_W-1:0] cw;
    logic [SYN_W-1:0]  syn;
    logic              par;
  } synd_t;

  function automatic logic is_pow2(input logic [SYN_W-1:0] p);
    return (p != '0) && ((p & (p - 6'd1)) == '0);
  endfunction

  // Data bit index carried by a non-power-of-two codeword position.
  // Position zero and every power of two below p are skipped.
  function automatic logic [SYN_W-1:0] data_index(input logic [SYN_W-1:0] p);
    logic [SYN_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < SYN_W; i++) begin
      if (p >= (6'd1 << i)) begin
        cnt = cnt + 6'd1;
      end
    end
    return p - cnt - 6'd1;
  endfunction

  // Positions whose index has a given bit set.
  function automatic logic [CODE_W-1:0] pos_mask(input int bitno);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int p = 0; p < CODE_W; p++) begin
      m[p] = p[bitno];
    end
    return m;
  endfunction

  // Least r, at least 1, with 2^r >= k + r + 1.
  function automatic logic [2:0] parity_count(input logic [SYN_W-1:0] k);
    logic [2:0] r;
    r = 3'd7;
    for (int i = 7; i >= 1; i--) begin
      if ((8'd1 << i) >= ({2'b00, k} + 8'(i) + 8'd1)) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  // Largest block size whose codeword fits into m bits.
  function automatic int max_data_bits(input int m);
    int kmax;
    kmax = 1;
    for (int t = 1; t < 64; t++) begin
      if (t + int'(parity_count(6'(t))) + 1 <= m) begin
        kmax = t;
      end
    end
    return kmax;
  endfunction

endpackage

>>> design/hsc_place.sv
module hsc_place (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          cmd_i,
  input  logic [hsc_pkg::CODE_W-1:0]    word_i,
  input  logic [hsc_pkg::CODE_W-1:0]    mask_i,
  output logic                          valid_o,
  output hsc_pkg::place_t               place_o
);
  import hsc_pkg::*;

  logic [CODE_W-1:0] scat;
  place_t            place_d, place_q;
  logic              valid_q;

  // Spread data bits over the positions that are not powers of two.
  always_comb begin
    scat = '0;
    for (int p = 1; p < CODE_W; p++) begin
      if (!is_pow2(6'(p))) begin
        scat[p] = word_i[data_index(6'(p))];
      end
    end
  end

  // Decode keeps the codeword as is; both are cut to the block length.
  always_comb begin
    place_d.cmd = cmd_i;
    place_d.cw  = (cmd_i == CMD_DECODE) ? (word_i & mask_i) : (scat & mask_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    place_q <= place_d;
  end

  assign valid_o = valid_q;
  assign place_o = place_q;

endmodule

>>> design/hsc_syndrome.sv
module hsc_syndrome (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  hsc_pkg::place_t place_i,
  output logic            valid_o,
  output hsc_pkg::synd_t  synd_o
);
  import hsc_pkg::*;

  synd_t synd_d, synd_q;
  logic  valid_q;

  // One parity tree per syndrome bit, plus the overall parity.
  always_comb begin
    synd_d.cmd = place_i.cmd;
    synd_d.cw  = place_i.cw;
    for (int i = 0; i < SYN_W; i++) begin
      synd_d.syn[i] = ^(place_i.cw & pos_mask(i));
    end
    synd_d.par = ^place_i.cw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    synd_q <= synd_d;
  end

  assign valid_o = valid_q;
  assign synd_o  = synd_q;

endmodule

>>> design/hsc_resolve.sv
module hsc_resolve (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  hsc_pkg::synd_t                synd_i,
  input  logic [hsc_pkg::CNT_W-1:0]     code_len_i,
  output logic                          valid_o,
  output logic [hsc_pkg::CODE_W-1:0]    word_o,
  output logic [1:0]                    status_o,
  output logic [hsc_pkg::SYN_W-1:0]     epos_o
);
  import hsc_pkg::*;

  logic [CODE_W-1:0] enc_cw;
  logic [CODE_W-1:0] fix_cw;
  logic [CODE_W-1:0] data;
  status_e           st;
  logic [SYN_W-1:0]  epos;
  logic              flip;
  logic [CODE_W-1:0] word_d, word_q;
  logic [1:0]        status_q;
  logic [SYN_W-1:0]  epos_q;
  logic              valid_q;

  // Encode: drop the check bits into place and close the overall parity.
  always_comb begin
    enc_cw = synd_i.cw;
    for (int i = 0; i < SYN_W; i++) begin
      enc_cw[1 << i] = synd_i.syn[i];
    end
    enc_cw[0] = synd_i.par ^ (^synd_i.syn);
  end

  // Decode: classify the error from syndrome and overall parity.
  always_comb begin
    st   = ST_CLEAN;
    epos = '0;
    flip = 1'b0;
    if (synd_i.syn == '0) begin
      st = synd_i.par ? ST_SINGLE : ST_CLEAN;
    end else if (!synd_i.par) begin
      st   = ST_DOUBLE;
      epos = synd_i.syn;
    end else if ({1'b0, synd_i.syn} >= code_len_i) begin
      st   = ST_RANGE;
      epos = synd_i.syn;
    end else begin
      st   = ST_SINGLE;
      epos = synd_i.syn;
      flip = 1'b1;
    end
  end

  // Correct the flagged bit and pull the data bits back out.
  always_comb begin
    fix_cw = synd_i.cw;
    if (flip) begin
      fix_cw[synd_i.syn] = ~synd_i.cw[synd_i.syn];
    end
    data = '0;
    for (int p = 1; p < CODE_W; p++) begin
      if (!is_pow2(6'(p))) begin
        data[data_index(6'(p))] = fix_cw[p];
      end
    end
  end

  assign word_d = (synd_i.cmd == CMD_DECODE) ? data : enc_cw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    status_q <= (synd_i.cmd == CMD_DECODE) ? st : ST_CLEAN;
    epos_q   <= (synd_i.cmd == CMD_DECODE) ? epos : '0;
  end

  assign valid_o  = valid_q;
  assign word_o   = word_q;
  assign status_o = status_q;
  assign epos_o   = epos_q;

endmodule

>>> design/hamming_secded_block_codec.sv
// Extended Hamming SECDED codec with a configurable block size.
// Command channel: a word is taken on each rising edge with start high and
// busy low; cmd_i selects encode (data bits in word_in_i) or decode (codeword
// positions in word_in_i). busy stays low, so a word can enter every cycle.
// Result channel: result_valid_o is high for one cycle while word_out_o,
// status_o and error_position_o hold the result; the receiver cannot stall,
// so every result is taken in that cycle.
// Throughput is one word per cycle. The three register stages are bit
// placement, the syndrome parity trees, and correction with data extraction.
// Configuration: cfg_data_i sets the data bits per block when cfg_valid_i
// and cfg_ready_o are high; cfg_ready_o is always high. Zero acts as one and
// sizes that overflow MAX_CODE_BITS clamp to the largest fitting size.
// Write it only while no word is in flight.
// Reset clears the pipeline valid bits, drops words in flight, and sets
// the block size to eight data bits.
module hamming_secded_block_codec #(
  parameter int MAX_CODE_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cmd_i,
  input  logic [hsc_pkg::CODE_W-1:0] word_in_i,
  output logic                       result_valid_o,
  output logic [hsc_pkg::CODE_W-1:0] word_out_o,
  output logic [1:0]                 status_o,
  output logic [hsc_pkg::SYN_W-1:0]  error_position_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [hsc_pkg::SYN_W-1:0]  cfg_data_i
);
  import hsc_pkg::*;

  localparam int               KMAX   = max_data_bits(MAX_CODE_BITS);
  localparam logic [SYN_W-1:0] KMAX_K = SYN_W'(KMAX);

  logic [SYN_W-1:0]  data_bits_q;
  logic [SYN_W-1:0]  k_eff;
  logic [CNT_W-1:0]  code_len;
  logic [CODE_W-1:0] mask;
  logic              s1_valid, s2_valid;
  place_t            s1;
  synd_t             s2;

  // Block size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q <= 6'd8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      data_bits_q <= cfg_data_i;
    end
  end

  // Effective block size, codeword length and position mask.
  always_comb begin
    if (data_bits_q == '0) begin
      k_eff = 6'd1;
    end else if (data_bits_q > KMAX_K) begin
      k_eff = KMAX_K;
    end else begin
      k_eff = data_bits_q;
    end
    code_len = {1'b0, k_eff} + {4'b0000, parity_count(k_eff)} + 7'd1;
    mask     = code_len[6] ? '1 : ((64'd1 << code_len[5:0]) - 64'd1);
  end

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  hsc_place u_place (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .cmd_i   (cmd_i),
    .word_i  (word_in_i),
    .mask_i  (mask),
    .valid_o (s1_valid),
    .place_o (s1)
  );

  hsc_syndrome u_syndrome (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .place_i (s1),
    .valid_o (s2_valid),
    .synd_o  (s2)
  );

  hsc_resolve u_resolve (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s2_valid),
    .synd_i     (s2),
    .code_len_i (code_len),
    .valid_o    (result_valid_o),
    .word_o     (word_out_o),
    .status_o   (status_o),
    .epos_o     (error_position_o)
  );

`include "hamming_secded_block_codec_macros.svh"

  // Every accepted word yields its result after the placement, syndrome and resolve registers.
  `HSC_ASSERT_IMPL(a_latency, start && !busy, ##3 result_valid_o)
  // No result appears without an accepted word behind it.
  `HSC_ASSERT_IMPL(a_no_spurious, result_valid_o, $past(start && !busy, 3))
  // An encoded word always reports a clean status and no position.
  `HSC_ASSERT_IMPL(a_enc_clean, start && !busy && cmd_i == CMD_ENCODE, ##3 (status_o == ST_CLEAN && error_position_o == '0))
  // The codeword length never exceeds the configured maximum.
  `HSC_ASSERT_NEXT(a_len_fits, 1'b1, code_len <= CNT_W'(MAX_CODE_BITS))

endmodule

>>> sim/hamming_secded_block_codec_tb.sv
module hamming_secded_block_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsc_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_WORDS = 115;

  // One expected or observed result word.
  typedef struct {
    logic [CODE_W-1:0] word;
    status_e           status;
    logic [SYN_W-1:0]  epos;
  } codec_result_t;

  // Scoreboard: keeps its own copy of the block size register, predicts the
  // result of every accepted word and compares results in order.
  class codec_scoreboard;
    logic [SYN_W-1:0] size_reg;
    codec_result_t    expected_q[$];
    int unsigned      errors;

    function new();
      size_reg = 6'd8;
      errors   = 0;
    endfunction

    function void set_size(logic [SYN_W-1:0] v);
      size_reg = v;
    endfunction

    function int unsigned parity_len(int unsigned k);
      int unsigned r;
      r = 1;
      while ((1 << r) < k + r + 1) r++;
      return r;
    endfunction

    // Effective data bits: zero acts as one, oversize clamps to the largest fit.
    function int unsigned data_len();
      int unsigned k;
      int unsigned kmax;
      kmax = 1;
      for (int unsigned t = 1; t < 64; t++) begin
        if (t + parity_len(t) + 1 <= CODE_W) kmax = t;
      end
      k = size_reg;
      if (k < 1) k = 1;
      if (k > kmax) k = kmax;
      return k;
    endfunction

    function int unsigned code_len();
      int unsigned k;
      k = data_len();
      return k + parity_len(k) + 1;
    endfunction

    function codec_result_t predict(logic cmd, logic [CODE_W-1:0] w);
      codec_result_t     res;
      int unsigned       k, r, n, j, s, par;
      logic [CODE_W-1:0] cw, mask;
      k = data_len();
      r = parity_len(k);
      n = k + r + 1;
      mask = (n >= CODE_W) ? '1 : ((64'd1 << n) - 64'd1);
      res.word = '0;
      res.status = ST_CLEAN;
      res.epos = '0;
      if (cmd == CMD_ENCODE) begin
        // Scatter data bits into the non-power-of-two positions.
        cw = '0;
        j = 0;
        for (int unsigned p = 1; p < n; p++) begin
          if ((p & (p - 1)) != 0) begin
            cw[p] = w[j];
            j++;
          end
        end
        s = 0;
        for (int unsigned p = 0; p < n; p++) begin
          if (cw[p]) s ^= p;
        end
        for (int unsigned i = 0; i < r; i++) begin
          if ((s >> i) & 1) cw[1 << i] = 1'b1;
        end
        cw[0] = ^cw;
        res.word = cw;
      end else begin
        cw = w & mask;
        s = 0;
        par = 0;
        for (int unsigned p = 0; p < n; p++) begin
          if (cw[p]) begin
            s ^= p;
            par ^= 1;
          end
        end
        if (s == 0) begin
          if (par != 0) res.status = ST_SINGLE;
        end else if (par == 0) begin
          res.status = ST_DOUBLE;
          res.epos = SYN_W'(s);
        end else if (s >= n) begin
          res.status = ST_RANGE;
          res.epos = SYN_W'(s);
        end else begin
          res.status = ST_SINGLE;
          res.epos = SYN_W'(s);
          cw[s] = ~cw[s];
        end
        // Gather the data bits back out of the codeword.
        j = 0;
        for (int unsigned p = 1; p < n; p++) begin
          if ((p & (p - 1)) != 0) begin
            res.word[j] = cw[p];
            j++;
          end
        end
      end
      return res;
    endfunction

    function void note_word(logic cmd, logic [CODE_W-1:0] w);
      expected_q.insert(expected_q.size(), predict(cmd, w));
    endfunction

    function void check_result(logic [CODE_W-1:0] w, logic [1:0] st, logic [SYN_W-1:0] ep);
      codec_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result without a pending word: word_out %h status %0d error_position %0d",
               w, st, ep);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (w !== exp_res.word) begin
        $error("word_out: expected %h, got %h", exp_res.word, w);
        errors++;
      end
      if (st !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, st);
        errors++;
      end
      if (ep !== exp_res.epos) begin
        $error("error_position: expected %0d, got %0d", exp_res.epos, ep);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              cmd_i;
  logic [CODE_W-1:0] word_in_i;
  logic              result_valid_o;
  logic [CODE_W-1:0] word_out_o;
  logic [1:0]        status_o;
  logic [SYN_W-1:0]  error_position_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [SYN_W-1:0]  cfg_data_i;

  codec_scoreboard sb;
  bit              idle_on;
  int unsigned     stall_cycles;

  hamming_secded_block_codec DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .word_in_i        (word_in_i),
    .result_valid_o   (result_valid_o),
    .word_out_o       (word_out_o),
    .status_o         (status_o),
    .error_position_o (error_position_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Every result strobe is taken in its cycle and checked.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result(word_out_o, status_o, error_position_o);
    end
  end

  // Watchdog on cycles without any accepted word, result or register write.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("hamming_secded_block_codec_tb: errors");
        $finish;
      end
    end
  end

  // Offer one word until accepted, then optionally idle with start low.
  task automatic send_word(input logic c, input logic [CODE_W-1:0] w);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    start <= 1'b1;
    cmd_i <= c;
    word_in_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_word(c, w);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every expected result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SYN_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_size(v);
  endtask

  function automatic logic [CODE_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Valid codeword of the current size for the given data.
  function automatic logic [CODE_W-1:0] codeword_of(logic [CODE_W-1:0] d);
    codec_result_t enc;
    enc = sb.predict(CMD_ENCODE, d);
    return enc.word;
  endfunction

  // Mostly codewords with zero, one or two flipped bits; the rest are encodes of random data or random words to decode.
  task automatic rand_item(output logic c, output logic [CODE_W-1:0] w);
    int unsigned       n, kind, flips, p1, p2;
    logic [CODE_W-1:0] mask;
    n = sb.code_len();
    mask = (n >= CODE_W) ? '1 : ((64'd1 << n) - 64'd1);
    kind = $urandom_range(0, 9);
    w = rand_word();
    if (kind < 2) begin
      c = CMD_ENCODE;
    end else if (kind == 2) begin
      c = CMD_DECODE;
    end else begin
      c = CMD_DECODE;
      w = codeword_of(rand_word());
      flips = $urandom_range(0, 3);
      p1 = $urandom_range(0, n - 1);
      p2 = $urandom_range(0, n - 1);
      while (p2 == p1) p2 = $urandom_range(0, n - 1);
      if (flips != 0) w[p1] = ~w[p1];
      if (flips == 3) w[p2] = ~w[p2];
      if ($urandom_range(0, 1) == 1) w = w | (rand_word() & ~mask);
    end
  endtask

  initial begin
    logic [SYN_W-1:0]  size_list [8];
    logic              c;
    logic [CODE_W-1:0] w;
    int unsigned       hold_at;

    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = CMD_ENCODE;
    word_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    idle_on = 1'b1;
    size_list = '{6'd1, 6'd4, 6'd11, 6'd26, 6'd57, 6'd63, 6'd0, 6'd2};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset size of eight data bits.
    send_word(CMD_ENCODE, '0);
    send_word(CMD_ENCODE, '1);
    send_word(CMD_ENCODE, 64'hA5);
    send_word(CMD_DECODE, codeword_of(64'hA5));
    send_word(CMD_DECODE, codeword_of(64'hA5) ^ (64'd1 << 5));
    send_word(CMD_DECODE, codeword_of(64'h3C) ^ 64'd1);
    send_word(CMD_DECODE, codeword_of(64'h5A) ^ (64'd1 << 3) ^ (64'd1 << 9));
    // Positions 2, 4 and 8 give a syndrome past the 13-bit codeword.
    send_word(CMD_DECODE, 64'h114);
    send_word(CMD_DECODE, '1);
    send_word(CMD_DECODE, codeword_of(64'hFF) ^ (64'd1 << 12));
    wait_drained();

    // Zero acts as a one-bit block.
    write_size(6'd0);
    send_word(CMD_ENCODE, 64'd1);
    send_word(CMD_ENCODE, '1);
    send_word(CMD_DECODE, '1);
    send_word(CMD_DECODE, codeword_of(64'd1) ^ (64'd1 << 3));
    wait_drained();

    // Oversize clamps to the full 64-bit codeword.
    write_size(6'd63);
    send_word(CMD_ENCODE, '1);
    send_word(CMD_DECODE, codeword_of('1) ^ (64'd1 << 63));
    send_word(CMD_DECODE, codeword_of(64'h0123_4567_89AB_CDEF) ^ (64'd1 << 62) ^ 64'd2);
    send_word(CMD_DECODE, codeword_of(64'h0F0F_0F0F_0F0F_0F0F) ^ 64'd1);
    wait_drained();

    write_size(6'd57);
    send_word(CMD_ENCODE, rand_word());
    send_word(CMD_DECODE, rand_word());
    send_word(CMD_DECODE, codeword_of('1));
    wait_drained();

    // Random phases, each at its own block size and idling style.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      write_size(ph < 8 ? size_list[ph] : SYN_W'($urandom_range(0, 63)));
      idle_on = ($urandom_range(0, 3) != 0);
      hold_at = (ph == 0) ? 40 : $urandom_range(0, 3 * PHASE_WORDS);
      for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
        if (i == hold_at) wait_drained();
        rand_item(c, w);
        send_word(c, w);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("hamming_secded_block_codec_tb: clean");
    end else begin
      $display("hamming_secded_block_codec_tb: errors");
    end
    $finish;
  end

endmodule
